>>> sv/lav_pkg.sv
// lav_pkg: shared widths, word types and register indexes for the look-at view matrix
// no dependencies; imported by every module of the block
package lav_pkg;

  localparam int AXIS_FRAC_BITS = 14;
  localparam int CW     = 32;                      // coordinate width, q16.16
  localparam int AW     = 16;                      // axis entry width
  localparam int NW     = CW + AW + 2;             // normalizer input width
  localparam int SW     = 30;                      // scaled magnitude width
  localparam int SQW    = 2 * SW + 2;              // sum of squares width
  localparam int RTW    = SW + 1;                  // square root width
  localparam int RMW    = RTW + 3;                 // square root remainder width
  localparam int QB     = AXIS_FRAC_BITS + 2;      // quotient bits
  localparam int NUMW   = SW + AXIS_FRAC_BITS + 1; // dividend width
  localparam int CFG_AW = 2;
  localparam int RND_HALF = 1 << (AXIS_FRAC_BITS - 1);
  localparam logic signed [CW-1:0] UP_Y_RESET = CW'(65536);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [AW-1:0] axis_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_UP_X,
    REG_UP_Y,
    REG_UP_Z
  } cfg_reg_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t aim_x;
    coord_t aim_y;
    coord_t aim_z;
  } in_word_t;

  typedef struct packed {
    axis_t  right_x;
    axis_t  right_y;
    axis_t  right_z;
    axis_t  upward_x;
    axis_t  upward_y;
    axis_t  upward_z;
    axis_t  back_x;
    axis_t  back_y;
    axis_t  back_z;
    coord_t shift_x;
    coord_t shift_y;
    coord_t shift_z;
  } out_word_t;

  typedef struct packed {
    coord_t [2:0] eye;
    axis_t  [2:0] back;
  } side_t;

  typedef struct packed {
    side_t             side;
    logic [2:0]        neg;
    logic              zero;
    logic [2:0][SW-1:0] sm;
  } nctx_t;

endpackage

>>> sv/lav_sqrt.sv
// lav_sqrt: pipelined integer square root, one result bit per stage, context carried along
// depends on lav_pkg
module lav_sqrt import lav_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_v,
  input  logic [SQW-1:0] in_rad,
  input  nctx_t          in_ctx,
  output logic           out_v,
  output logic [RTW-1:0] out_root,
  output nctx_t          out_ctx
);

  logic [RTW:1]    v_r;
  logic [SQW-1:0]  rad_r  [1:RTW];
  logic [RMW-1:0]  rem_r  [1:RTW];
  logic [RTW-1:0]  root_r [1:RTW];
  nctx_t           ctx_r  [1:RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_step
    logic           v_i;
    logic [SQW-1:0] rad_i;
    logic [RMW-1:0] rem_i;
    logic [RTW-1:0] root_i;
    nctx_t          ctx_i;
    logic [RMW-1:0] acc;
    logic [RMW-1:0] trial;

    if (k == 0) begin : g_first
      assign v_i    = in_v;
      assign rad_i  = in_rad;
      assign rem_i  = '0;
      assign root_i = '0;
      assign ctx_i  = in_ctx;
    end else begin : g_next
      assign v_i    = v_r[k];
      assign rad_i  = rad_r[k];
      assign rem_i  = rem_r[k];
      assign root_i = root_r[k];
      assign ctx_i  = ctx_r[k];
    end

    assign acc   = {rem_i[RMW-3:0], rad_i[SQW-1:SQW-2]};
    assign trial = RMW'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (en) begin
        v_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[k+1] <= rad_i << 2;
        ctx_r[k+1] <= ctx_i;
        if (acc >= trial) begin
          rem_r[k+1]  <= acc - trial;
          root_r[k+1] <= {root_i[RTW-2:0], 1'b1};
        end else begin
          rem_r[k+1]  <= acc;
          root_r[k+1] <= {root_i[RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_v    = v_r[RTW];
  assign out_root = root_r[RTW];
  assign out_ctx  = ctx_r[RTW];

endmodule

>>> sv/lav_nrm.sv
// lav_nrm: pipelined vector normalizer, scale, sum of squares, root, per-bit divide
// depends on lav_pkg and lav_sqrt
module lav_nrm import lav_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_v,
  input  logic [2:0][NW-1:0] in_vec,
  input  side_t             in_side,
  output logic              out_v,
  output axis_t [2:0]       out_axis,
  output side_t             out_side
);

  function automatic logic [3:0][NW-1:0] nshift(input logic [3:0][NW-1:0] x, input int w);
    logic [3:0][NW-1:0] r;
    r = x;
    if ((x[3] >> (NW - w)) == '0) begin
      for (int i = 0; i < 4; i++) r[i] = x[i] << w;
    end
    return r;
  endfunction

  // magnitudes
  logic               v_a_r;
  logic [2:0][NW-1:0] m_a_r;
  nctx_t              ctx_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        m_a_r[i]       <= in_vec[i][NW-1] ? (~in_vec[i] + NW'(1)) : in_vec[i];
        ctx_a_r.neg[i] <= in_vec[i][NW-1];
      end
      ctx_a_r.side <= in_side;
      ctx_a_r.zero <= 1'b0;
      ctx_a_r.sm   <= '0;
    end
  end

  // largest magnitude
  logic               v_b_r;
  logic [3:0][NW-1:0] x_b_r;
  nctx_t              ctx_b_r;
  logic [NW-1:0]      top_a;

  always_comb begin
    top_a = m_a_r[0];
    if (m_a_r[1] > top_a) top_a = m_a_r[1];
    if (m_a_r[2] > top_a) top_a = m_a_r[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b_r <= 1'b0;
    end else if (en) begin
      v_b_r <= v_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_b_r        <= {top_a, m_a_r[2], m_a_r[1], m_a_r[0]};
      ctx_b_r.side <= ctx_a_r.side;
      ctx_b_r.neg  <= ctx_a_r.neg;
      ctx_b_r.zero <= (top_a == '0);
      ctx_b_r.sm   <= ctx_a_r.sm;
    end
  end

  // left normalize to the top bit, two steps per stage
  logic [3:1]         v_s_r;
  logic [3:0][NW-1:0] x_s_r   [1:3];
  nctx_t              ctx_s_r [1:3];

  for (genvar j = 0; j < 3; j++) begin : g_shift
    logic               v_i;
    logic [3:0][NW-1:0] x_i;
    nctx_t              ctx_i;

    if (j == 0) begin : g_first
      assign v_i   = v_b_r;
      assign x_i   = x_b_r;
      assign ctx_i = ctx_b_r;
    end else begin : g_next
      assign v_i   = v_s_r[j];
      assign x_i   = x_s_r[j];
      assign ctx_i = ctx_s_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_s_r[j+1] <= 1'b0;
      end else if (en) begin
        v_s_r[j+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_s_r[j+1]   <= nshift(nshift(x_i, 32 >> (2 * j)), 16 >> (2 * j));
        ctx_s_r[j+1] <= ctx_i;
      end
    end
  end

  // squares
  logic                 v_f_r;
  logic [2:0][2*SW-1:0] sq_f_r;
  nctx_t                ctx_f_r;
  logic [2:0][SW-1:0]   sm_e;

  always_comb begin
    for (int i = 0; i < 3; i++) sm_e[i] = x_s_r[3][i][NW-1:NW-SW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en) begin
      v_f_r <= v_s_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) sq_f_r[i] <= (2*SW)'(sm_e[i]) * (2*SW)'(sm_e[i]);
      ctx_f_r.side <= ctx_s_r[3].side;
      ctx_f_r.neg  <= ctx_s_r[3].neg;
      ctx_f_r.zero <= ctx_s_r[3].zero;
      ctx_f_r.sm   <= sm_e;
    end
  end

  // sum of squares
  logic           v_g_r;
  logic [SQW-1:0] sum_g_r;
  nctx_t          ctx_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (en) begin
      v_g_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_g_r <= SQW'(sq_f_r[0]) + SQW'(sq_f_r[1]) + SQW'(sq_f_r[2]);
      ctx_g_r <= ctx_f_r;
    end
  end

  logic           v_q;
  logic [RTW-1:0] root_q;
  nctx_t          ctx_q;

  lav_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_g_r),
    .in_rad   (sum_g_r),
    .in_ctx   (ctx_g_r),
    .out_v    (v_q),
    .out_root (root_q),
    .out_ctx  (ctx_q)
  );

  // dividends with rounding term
  logic                 v_h_r;
  logic [RTW-1:0]       n_h_r;
  logic [2:0][NUMW-1:0] num_h_r;
  nctx_t                ctx_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_h_r <= 1'b0;
    end else if (en) begin
      v_h_r <= v_q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_h_r[i] <= NUMW'({ctx_q.sm[i], AXIS_FRAC_BITS'(0)}) + NUMW'(root_q >> 1);
      end
      n_h_r   <= root_q;
      ctx_h_r <= ctx_q;
    end
  end

  // restoring divide, one quotient bit per stage
  logic [QB:1]          dv_r;
  logic [RTW-1:0]       dn_r   [1:QB];
  logic [2:0][RTW-1:0]  drem_r [1:QB];
  logic [2:0][QB-1:0]   dw_r   [1:QB];
  nctx_t                dctx_r [1:QB];

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic                v_i;
    logic [RTW-1:0]      n_i;
    logic [2:0][RTW-1:0] rem_i;
    logic [2:0][QB-1:0]  w_i;
    nctx_t               ctx_i;
    logic [2:0][RTW-1:0] rem_n;
    logic [2:0][QB-1:0]  w_n;

    if (k == 0) begin : g_first
      assign v_i   = v_h_r;
      assign n_i   = n_h_r;
      assign ctx_i = ctx_h_r;
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_i[i] = RTW'(num_h_r[i][NUMW-1:QB]);
        assign w_i[i]   = num_h_r[i][QB-1:0];
      end
    end else begin : g_next
      assign v_i   = dv_r[k];
      assign n_i   = dn_r[k];
      assign rem_i = drem_r[k];
      assign w_i   = dw_r[k];
      assign ctx_i = dctx_r[k];
    end

    always_comb begin
      logic [RTW:0] t;
      for (int i = 0; i < 3; i++) begin
        t = {rem_i[i], w_i[i][QB-1]};
        if (t >= {1'b0, n_i}) begin
          rem_n[i] = RTW'(t - {1'b0, n_i});
          w_n[i]   = {w_i[i][QB-2:0], 1'b1};
        end else begin
          rem_n[i] = RTW'(t);
          w_n[i]   = {w_i[i][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn_r[k+1]   <= n_i;
        drem_r[k+1] <= rem_n;
        dw_r[k+1]   <= w_n;
        dctx_r[k+1] <= ctx_i;
      end
    end
  end

  // sign and zero vector
  logic        out_v_r;
  axis_t [2:0] out_axis_r;
  side_t       out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= dv_r[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (dctx_r[QB].zero) begin
          out_axis_r[i] <= '0;
        end else if (dctx_r[QB].neg[i]) begin
          out_axis_r[i] <= -AW'(dw_r[QB][i]);
        end else begin
          out_axis_r[i] <= AW'(dw_r[QB][i]);
        end
      end
      out_side_r <= dctx_r[QB].side;
    end
  end

  assign out_v    = out_v_r;
  assign out_axis = out_axis_r;
  assign out_side = out_side_r;

endmodule

>>> sv/lav_frame.sv
// lav_frame: recomputed up axis and the three translation dot products, pipelined
// depends on lav_pkg
module lav_frame import lav_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_v,
  input  axis_t [2:0] in_right,
  input  side_t       in_side,
  output logic        out_v,
  output out_word_t   out_word
);

  localparam int UW = 2 * AW + 1;
  localparam int DW = AW + CW + 2;
  localparam int RW = DW - AXIS_FRAC_BITS;
  localparam int UR = UW - AXIS_FRAC_BITS;
  localparam longint CMAXL = (longint'(1) << (CW - 1)) - 1;
  localparam logic signed [RW:0]   SAT_HI = (RW+1)'(CMAXL);
  localparam logic signed [RW:0]   SAT_LO = (RW+1)'(-CMAXL - 1);
  localparam logic signed [UR-1:0] U_ONE  = UR'(1 << AXIS_FRAC_BITS);

  function automatic logic signed [UR-1:0] rnd_u(input logic signed [UW-1:0] x);
    logic signed [UW-1:0] s;
    s = x + (x[UW-1] ? UW'(RND_HALF - 1) : UW'(RND_HALF));
    return s[UW-1:AXIS_FRAC_BITS];
  endfunction

  function automatic logic signed [RW-1:0] rnd_d(input logic signed [DW-1:0] x);
    logic signed [DW-1:0] s;
    s = x + (x[DW-1] ? DW'(RND_HALF - 1) : DW'(RND_HALF));
    return s[DW-1:AXIS_FRAC_BITS];
  endfunction

  function automatic coord_t sat_neg(input logic signed [RW-1:0] x);
    logic signed [RW:0] n;
    n = -$signed({x[RW-1], x});
    if (n > SAT_HI) return CW'(SAT_HI);
    if (n < SAT_LO) return CW'(SAT_LO);
    return n[CW-1:0];
  endfunction

  function automatic axis_t clamp_u(input logic signed [UR-1:0] x);
    if (x > U_ONE) return AW'(U_ONE);
    if (x < -U_ONE) return AW'(-U_ONE);
    return x[AW-1:0];
  endfunction

  logic [8:1] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[7:1], in_v};
    end
  end

  // products
  axis_t  [2:0]             r1_r, b1_r;
  coord_t [2:0]             e1_r;
  logic signed [2*AW-1:0]   pu1_r [6];
  logic signed [AW+CW-1:0]  pr1_r [3];
  logic signed [AW+CW-1:0]  pb1_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= in_right;
      b1_r <= in_side.back;
      e1_r <= in_side.eye;
      pu1_r[0] <= $signed(in_side.back[1]) * $signed(in_right[2]);
      pu1_r[1] <= $signed(in_side.back[2]) * $signed(in_right[1]);
      pu1_r[2] <= $signed(in_side.back[2]) * $signed(in_right[0]);
      pu1_r[3] <= $signed(in_side.back[0]) * $signed(in_right[2]);
      pu1_r[4] <= $signed(in_side.back[0]) * $signed(in_right[1]);
      pu1_r[5] <= $signed(in_side.back[1]) * $signed(in_right[0]);
      for (int i = 0; i < 3; i++) begin
        pr1_r[i] <= $signed(in_right[i]) * $signed(in_side.eye[i]);
        pb1_r[i] <= $signed(in_side.back[i]) * $signed(in_side.eye[i]);
      end
    end
  end

  // differences and sums
  axis_t  [2:0]         r2_r, b2_r;
  coord_t [2:0]         e2_r;
  logic signed [UW-1:0] ud2_r [3];
  logic signed [DW-1:0] dr2_r, db2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r2_r <= r1_r;
      b2_r <= b1_r;
      e2_r <= e1_r;
      for (int i = 0; i < 3; i++) ud2_r[i] <= UW'(pu1_r[2*i]) - UW'(pu1_r[2*i+1]);
      dr2_r <= DW'(pr1_r[0]) + DW'(pr1_r[1]) + DW'(pr1_r[2]);
      db2_r <= DW'(pb1_r[0]) + DW'(pb1_r[1]) + DW'(pb1_r[2]);
    end
  end

  // rounding
  axis_t  [2:0]         r3_r, b3_r;
  coord_t [2:0]         e3_r;
  logic signed [UR-1:0] ur3_r [3];
  logic signed [RW-1:0] dr3_r, db3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r3_r <= r2_r;
      b3_r <= b2_r;
      e3_r <= e2_r;
      for (int i = 0; i < 3; i++) ur3_r[i] <= rnd_u(ud2_r[i]);
      dr3_r <= rnd_d(dr2_r);
      db3_r <= rnd_d(db2_r);
    end
  end

  // clamp and saturate
  axis_t  [2:0] r4_r, b4_r, u4_r;
  coord_t [2:0] e4_r;
  coord_t       sx4_r, sz4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r4_r <= r3_r;
      b4_r <= b3_r;
      e4_r <= e3_r;
      for (int i = 0; i < 3; i++) u4_r[i] <= clamp_u(ur3_r[i]);
      sx4_r <= sat_neg(dr3_r);
      sz4_r <= sat_neg(db3_r);
    end
  end

  // up axis dot eye
  axis_t  [2:0]            r5_r, b5_r, u5_r;
  coord_t                  sx5_r, sz5_r;
  logic signed [AW+CW-1:0] pe5_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      r5_r  <= r4_r;
      b5_r  <= b4_r;
      u5_r  <= u4_r;
      sx5_r <= sx4_r;
      sz5_r <= sz4_r;
      for (int i = 0; i < 3; i++) pe5_r[i] <= $signed(u4_r[i]) * $signed(e4_r[i]);
    end
  end

  axis_t  [2:0]         r6_r, b6_r, u6_r;
  coord_t               sx6_r, sz6_r;
  logic signed [DW-1:0] du6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r6_r  <= r5_r;
      b6_r  <= b5_r;
      u6_r  <= u5_r;
      sx6_r <= sx5_r;
      sz6_r <= sz5_r;
      du6_r <= DW'(pe5_r[0]) + DW'(pe5_r[1]) + DW'(pe5_r[2]);
    end
  end

  axis_t  [2:0]         r7_r, b7_r, u7_r;
  coord_t               sx7_r, sz7_r;
  logic signed [RW-1:0] du7_r;

  always_ff @(posedge clk) begin
    if (en) begin
      r7_r  <= r6_r;
      b7_r  <= b6_r;
      u7_r  <= u6_r;
      sx7_r <= sx6_r;
      sz7_r <= sz6_r;
      du7_r <= rnd_d(du6_r);
    end
  end

  out_word_t word8_r;

  always_ff @(posedge clk) begin
    if (en) begin
      word8_r.right_x  <= r7_r[0];
      word8_r.right_y  <= r7_r[1];
      word8_r.right_z  <= r7_r[2];
      word8_r.upward_x <= u7_r[0];
      word8_r.upward_y <= u7_r[1];
      word8_r.upward_z <= u7_r[2];
      word8_r.back_x   <= b7_r[0];
      word8_r.back_y   <= b7_r[1];
      word8_r.back_z   <= b7_r[2];
      word8_r.shift_x  <= sx7_r;
      word8_r.shift_y  <= sat_neg(du7_r);
      word8_r.shift_z  <= sz7_r;
    end
  end

  assign out_v    = v_r[8];
  assign out_word = word8_r;

endmodule

>>> sv/look_at_view_matrix.sv
// look_at_view_matrix: top level, up vector registers, back and right axes, output skid
// depends on lav_pkg, lav_nrm, lav_frame
//
//   port group | dir | handshake         | payload
//   in_        | in  | in_valid/in_ready | in_data (in_word_t)
//   out_       | out | out_valid/out_ready | out_data (out_word_t)
//   cfg_       | in  | cfg_we            | cfg_addr, cfg_wdata
//
// one word per cycle while the skid register is empty
// most of the pipeline lies in two normalizers: 31 square root stages and 16 divide stages each
// reset is synchronous and clears valid bits and the up vector to (0, 1.0, 0)
// a waiting output word parks the next one in a skid register, then the pipeline holds
module look_at_view_matrix import lav_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_data,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CW-1:0]     cfg_wdata
);

  coord_t up_x_r, up_y_r, up_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= '0;
      up_y_r <= UP_Y_RESET;
      up_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_UP_X: up_x_r <= cfg_wdata;
        REG_UP_Y: up_y_r <= cfg_wdata;
        REG_UP_Z: up_z_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_v_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  // eye minus aim
  logic                 v_t0_r;
  coord_t [2:0]         eye_t0_r;
  logic signed [CW:0]   dif_t0_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_t0_r <= 1'b0;
    end else if (en) begin
      v_t0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      eye_t0_r    <= {in_data.eye_z, in_data.eye_y, in_data.eye_x};
      dif_t0_r[0] <= $signed({in_data.eye_x[CW-1], in_data.eye_x})
                   - $signed({in_data.aim_x[CW-1], in_data.aim_x});
      dif_t0_r[1] <= $signed({in_data.eye_y[CW-1], in_data.eye_y})
                   - $signed({in_data.aim_y[CW-1], in_data.aim_y});
      dif_t0_r[2] <= $signed({in_data.eye_z[CW-1], in_data.eye_z})
                   - $signed({in_data.aim_z[CW-1], in_data.aim_z});
    end
  end

  logic [2:0][NW-1:0] vec1;
  side_t              side1;

  always_comb begin
    for (int i = 0; i < 3; i++) vec1[i] = NW'(dif_t0_r[i]);
    side1.eye  = eye_t0_r;
    side1.back = '0;
  end

  logic        v_n1;
  axis_t [2:0] back_n1;
  side_t       side_n1;

  lav_nrm u_nrm_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_t0_r),
    .in_vec   (vec1),
    .in_side  (side1),
    .out_v    (v_n1),
    .out_axis (back_n1),
    .out_side (side_n1)
  );

  // up cross back
  logic                    v_t1_r;
  side_t                   side_t1_r;
  logic signed [CW+AW-1:0] pc_t1_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_t1_r <= 1'b0;
    end else if (en) begin
      v_t1_r <= v_n1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_t1_r.eye  <= side_n1.eye;
      side_t1_r.back <= back_n1;
      pc_t1_r[0] <= $signed(up_y_r) * $signed(back_n1[2]);
      pc_t1_r[1] <= $signed(up_z_r) * $signed(back_n1[1]);
      pc_t1_r[2] <= $signed(up_z_r) * $signed(back_n1[0]);
      pc_t1_r[3] <= $signed(up_x_r) * $signed(back_n1[2]);
      pc_t1_r[4] <= $signed(up_x_r) * $signed(back_n1[1]);
      pc_t1_r[5] <= $signed(up_y_r) * $signed(back_n1[0]);
    end
  end

  logic               v_t2_r;
  side_t              side_t2_r;
  logic [2:0][NW-1:0] cr_t2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_t2_r <= 1'b0;
    end else if (en) begin
      v_t2_r <= v_t1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_t2_r <= side_t1_r;
      for (int i = 0; i < 3; i++) cr_t2_r[i] <= NW'(pc_t1_r[2*i]) - NW'(pc_t1_r[2*i+1]);
    end
  end

  logic        v_n2;
  axis_t [2:0] right_n2;
  side_t       side_n2;

  lav_nrm u_nrm_right (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_t2_r),
    .in_vec   (cr_t2_r),
    .in_side  (side_t2_r),
    .out_v    (v_n2),
    .out_axis (right_n2),
    .out_side (side_n2)
  );

  logic      p_v;
  out_word_t p_word;

  lav_frame u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (v_n2),
    .in_right (right_n2),
    .in_side  (side_n2),
    .out_v    (p_v),
    .out_word (p_word)
  );

  // output register and skid
  logic      out_v_r;
  out_word_t out_r;
  out_word_t skid_r;
  logic      out_free;

  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= p_v;
      end
    end else if (en && p_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_v_r ? skid_r : p_word;
    end
    if (!out_free && en && p_v) begin
      skid_r <= p_word;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> dv/look_at_view_matrix_tb.sv
// look_at_view_matrix_tb: random and directed test of the look-at view matrix block
// depends on lav_pkg and look_at_view_matrix; predicts each output word in fixed point
module look_at_view_matrix_tb;
  import lav_pkg::*;

  localparam int WATCHDOG = 20000;
  localparam int LATENCY = 124;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic in_acc = 1'b0;

  in_word_t pending_words[$];
  out_word_t expected_frames[$];
  longint up_vec[3];
  int errors = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int out_gap = 0;

  look_at_view_matrix dut (.*);

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned mag(longint x);
    return x < 0 ? 64'(-x) : 64'(x);
  endfunction

  typedef longint vec_t[3];

  function automatic vec_t unit_vec(vec_t a);
    vec_t r;
    longint unsigned m[3];
    longint unsigned top, sum, n, q;
    top = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(a[i]);
      if (m[i] > top) top = m[i];
    end
    if (top == 0) begin
      r = '{0, 0, 0};
      return r;
    end
    while (top >= (64'd1 << 30)) begin
      top >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (top < (64'd1 << 29)) begin
      top <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    n = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << AXIS_FRAC_BITS) + (n >> 1)) / n;
      r[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    return r;
  endfunction

  function automatic vec_t cross3(vec_t a, vec_t b);
    vec_t r;
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
    return r;
  endfunction

  function automatic longint round_away(longint v);
    longint unsigned m;
    m = (mag(v) + (64'd1 << (AXIS_FRAC_BITS - 1))) >> AXIS_FRAC_BITS;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic out_word_t view_frame(in_word_t w);
    vec_t eye, dif, up, back, right, upward;
    vec_t axes[3];
    longint one, dot;
    out_word_t o;
    one = longint'(1) << AXIS_FRAC_BITS;
    eye = '{longint'(w.eye_x), longint'(w.eye_y), longint'(w.eye_z)};
    dif = '{eye[0] - longint'(w.aim_x), eye[1] - longint'(w.aim_y),
            eye[2] - longint'(w.aim_z)};
    up = up_vec;
    back = unit_vec(dif);
    right = unit_vec(cross3(up, back));
    upward = cross3(back, right);
    for (int i = 0; i < 3; i++) upward[i] = clamp(round_away(upward[i]), -one, one);
    o.right_x = AW'(right[0]);
    o.right_y = AW'(right[1]);
    o.right_z = AW'(right[2]);
    o.upward_x = AW'(upward[0]);
    o.upward_y = AW'(upward[1]);
    o.upward_z = AW'(upward[2]);
    o.back_x = AW'(back[0]);
    o.back_y = AW'(back[1]);
    o.back_z = AW'(back[2]);
    axes[0] = right;
    axes[1] = upward;
    axes[2] = back;
    for (int i = 0; i < 3; i++) begin
      dot = axes[i][0] * eye[0] + axes[i][1] * eye[1] + axes[i][2] * eye[2];
      dot = clamp(-round_away(dot), -64'sd2147483648, 64'sd2147483647);
      if (i == 0) o.shift_x = CW'(dot);
      else if (i == 1) o.shift_y = CW'(dot);
      else o.shift_z = CW'(dot);
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return CW'($signed($urandom_range(0, 2000)) - 1000) << 16;
      2: return CW'($signed($urandom_range(0, 200)) - 100);
      3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return CW'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
    endcase
  endfunction

  function automatic in_word_t rand_word();
    in_word_t w;
    w.eye_x = rand_coord();
    w.eye_y = rand_coord();
    w.eye_z = rand_coord();
    if ($urandom_range(0, 19) == 0) begin
      w.aim_x = w.eye_x;
      w.aim_y = w.eye_y;
      w.aim_z = w.eye_z;
    end else if ($urandom_range(0, 19) == 0) begin
      // line of sight along the up vector
      w.aim_x = w.eye_x - CW'(up_vec[0]);
      w.aim_y = w.eye_y - CW'(up_vec[1]);
      w.aim_z = w.eye_z - CW'(up_vec[2]);
    end else begin
      w.aim_x = rand_coord();
      w.aim_y = rand_coord();
      w.aim_z = rand_coord();
    end
    return w;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && in_acc) begin
        void'(pending_words.pop_front());
        in_gap = pick_gap();
      end
      if (!in_valid || in_acc) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_words[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) out_gap = pick_gap();
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      in_acc <= in_valid && in_ready;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_valid && in_ready) begin
        expected_frames.push_back(view_frame(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_frames.size() == 0) begin
          errors++;
          $display("%0t: unexpected word %h", $time, out_data);
        end else begin
          out_word_t e;
          e = expected_frames.pop_front();
          if (e !== out_data) begin
            errors++;
            $display("%0t: mismatch expected %h actual %h", $time, e, out_data);
          end
        end
      end
      if (idle_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_up(cfg_reg_t idx, logic [CW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    up_vec[int'(idx)] = longint'($signed(val));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() > 0 || in_valid || expected_frames.size() > 0)
      @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic push_directed(logic [CW-1:0] ex, ey, ez, ax, ay, az);
    in_word_t w;
    w = '{ex, ey, ez, ax, ay, az};
    pending_words.push_back(w);
  endtask

  initial begin
    up_vec = '{0, 65536, 0};
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    push_directed(0, 0, 32'h50000, 0, 0, 0);
    push_directed(0, 0, 0, 0, 0, 0);
    push_directed(0, 32'h30000, 0, 0, 0, 0);
    push_directed(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                  32'h80000000, 32'h80000000, 32'h80000000);
    push_directed(32'h80000000, 32'h80000000, 32'h80000000,
                  32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    push_directed(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    push_directed(1, 0, 0, 0, 0, 0);
    push_directed(32'hffffffff, 32'h1, 32'hffffffff, 0, 0, 0);
    push_directed(32'h12345678, 32'hedcba987, 32'h0badf00d,
                  32'h0000ffff, 32'hffff0000, 32'h55555555);
    push_directed(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                  32'h55555555, 32'haaaaaaaa, 32'h55555555);
    for (int i = 0; i < 10; i++) pending_words.push_back(rand_word());
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          write_up(REG_UP_X, 32'h7fffffff);
          write_up(REG_UP_Y, 32'h80000000);
          write_up(REG_UP_Z, 32'h7fffffff);
        end
        1: begin
          write_up(REG_UP_X, 0);
          write_up(REG_UP_Y, 0);
          write_up(REG_UP_Z, 0);
        end
        2: begin
          write_up(REG_UP_X, 32'h80000000);
          write_up(REG_UP_Y, 32'h1);
          write_up(REG_UP_Z, 32'hffffffff);
        end
        default: begin
          write_up(REG_UP_X, rand_coord());
          write_up(REG_UP_Y, rand_coord());
          write_up(REG_UP_Z, rand_coord());
        end
      endcase
      if (phase == 1) begin
        push_directed(0, 0, 32'h10000, 0, 0, 0);
        push_directed(32'h10000, 32'h20000, 0, 0, 0, 0);
      end
      for (int i = 0; i < 290; i++) pending_words.push_back(rand_word());
      drain();
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/lav_pkg.sv
sv/lav_sqrt.sv
sv/lav_nrm.sv
sv/lav_frame.sv
sv/look_at_view_matrix.sv
dv/look_at_view_matrix_tb.sv
